/* rtl/ita_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ita_pkg
// Shared types, constants and digit mapping of the integer-to-text converter.
// ---------------------------------------------------------------------------
package ita_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   localparam int unsigned RADIX_W       = 6;
   localparam int unsigned CHAR_W        = 7;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 7'h2d;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
   // 'a' minus ten, so digit 10 maps to 'a'
   localparam logic [CHAR_W-1:0]  CHAR_ALPHA0 = 7'h57;

   // map one digit 0..35 to lower-case ASCII
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = {1'b0, d};
      if (d < RADIX_DEC) begin
         return CHAR_ZERO + dx;
      end else begin
         return CHAR_ALPHA0 + dx;
      end
   endfunction

endpackage
`default_nettype wire

/* rtl/int_to_ascii_radix.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// int_to_ascii_radix
// Signed integer to lower-case ASCII text in a programmable radix (2..36).
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: one beat carries a signed INPUT_BITS-bit value. req_ready is
//    high only while the converter is idle.
//  - rsp channel: one beat per character, most significant digit first;
//    rsp_last marks the final character of a value. In radix ten a negative
//    value starts with '-'; other radixes print the value sign-extended to a
//    WORD_BITS-bit unsigned word.
//  - csr channel: always ready; writes the radix. Writes outside 2..36 are
//    dropped and the old radix stays. Write only while the block is idle.
//  - Operation: each digit costs one restoring division by the radix on a
//    single shared subtract/compare unit, one quotient bit per cycle, over
//    MAG_W quotient bits (MAG_W = max(INPUT_BITS, WORD_BITS), 32 by
//    default). An item is accepted, runs its divisions one digit after
//    another, then gives one output beat per character. Radix two on a
//    negative value is the worst case: 32 digits by default.
//  - Reset (synchronous, active high) returns to idle and sets radix ten.
//  - A stalled receiver simply holds the current character; rsp_valid and
//    the payload stay put until taken.
// ---------------------------------------------------------------------------
module int_to_ascii_radix #(
   parameter int unsigned INPUT_BITS = 16,
   parameter int unsigned WORD_BITS  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic signed [INPUT_BITS-1:0] req_value,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [ita_pkg::CHAR_W-1:0]  rsp_char_code,
   output      logic                  rsp_last,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [ita_pkg::RADIX_W-1:0] csr_radix
);
   import ita_pkg::*;

   // width of the working magnitude: holds the word and any decimal magnitude
   localparam int unsigned MAG_W = (WORD_BITS > INPUT_BITS) ? WORD_BITS : INPUT_BITS;
   localparam int unsigned BIT_W = $clog2(MAG_W);
   localparam int unsigned CNT_W = $clog2(MAG_W + 1);
   localparam logic [MAG_W-1:0] WORD_MASK = MAG_W'({WORD_BITS{1'b1}});
   localparam logic [BIT_W-1:0] BIT_LAST  = BIT_W'(MAG_W - 1);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   state_type state_ff, state_in;

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [MAG_W-1:0]   quo_ff, quo_in;      // dividend shifting out, quotient in
   logic [RADIX_W-1:0] rem_ff, rem_in;      // partial remainder, always < radix
   logic [BIT_W-1:0]   bit_ff, bit_in;      // quotient bit position
   logic [CNT_W-1:0]   cnt_ff, cnt_in;      // digits on the stack
   logic               sign_ff, sign_in;    // '-' still owed in front
   logic [RADIX_W-1:0] stack_ff [MAG_W];    // digit LIFO, top at entry 0
   logic [RADIX_W-1:0] stack_in [MAG_W];

   // shared divide step
   logic [RADIX_W:0]   rem_sh;
   logic               q_bit;
   logic [RADIX_W-1:0] rem_new;
   logic [MAG_W-1:0]   quo_new;
   logic               digit_done;

   // accept-time operand prep
   logic [MAG_W-1:0]   ext;
   logic               neg;
   logic               dec_neg;

   logic req_beat, rsp_beat, push, pop;

   assign csr_ready = 1'b1;
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;

   // one restoring step: shift in the next dividend bit, trial subtract
   always_comb begin
      rem_sh     = {rem_ff, quo_ff[MAG_W-1]};
      q_bit      = (rem_sh >= {1'b0, radix_ff});
      rem_new    = q_bit ? RADIX_W'(rem_sh - {1'b0, radix_ff}) : RADIX_W'(rem_sh);
      quo_new    = {quo_ff[MAG_W-2:0], q_bit};
      digit_done = (state_ff == ST_DIV) && (bit_ff == BIT_LAST);
   end

   always_comb begin
      neg     = req_value[INPUT_BITS-1];
      ext     = MAG_W'(signed'(req_value));
      dec_neg = neg && (radix_ff == RADIX_DEC);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (digit_done && (quo_new == '0)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_beat && !sign_ff && (cnt_ff == CNT_ONE)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      rsp_char_code = digit_char(stack_ff[0]);
      rsp_last      = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DIV:  req_ready = 1'b0;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (sign_ff) begin
               rsp_char_code = CHAR_MINUS;
            end else begin
               rsp_last = (cnt_ff == CNT_ONE);
            end
         end
         default: req_ready = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      radix_in = radix_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      sign_in  = sign_ff;
      push     = 1'b0;
      pop      = 1'b0;

      if (csr_valid && csr_ready && (csr_radix >= RADIX_MIN) && (csr_radix <= RADIX_MAX)) begin
         radix_in = csr_radix;
      end

      if (req_beat) begin
         // load operand: decimal negatives become their magnitude
         quo_in  = dec_neg ? (MAG_W'(0) - ext) : (ext & WORD_MASK);
         rem_in  = '0;
         bit_in  = '0;
         cnt_in  = '0;
         sign_in = dec_neg;
      end else if (state_ff == ST_DIV) begin
         if (digit_done) begin
            // push remainder digit, restart on the quotient
            push   = 1'b1;
            cnt_in = cnt_ff + CNT_ONE;
            quo_in = quo_new;
            rem_in = '0;
            bit_in = '0;
         end else begin
            quo_in = quo_new;
            rem_in = rem_new;
            bit_in = bit_ff + BIT_W'(1);
         end
      end else if ((state_ff == ST_EMIT) && rsp_beat) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            pop    = 1'b1;
            cnt_in = cnt_ff - CNT_ONE;
         end
      end
   end

   // digit LIFO: push shifts up, pop shifts down
   always_comb begin
      for (int i = 0; i < MAG_W; i++) begin
         stack_in[i] = stack_ff[i];
      end
      if (push) begin
         stack_in[0] = rem_new;
         for (int i = 1; i < MAG_W; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < MAG_W - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_DEC;
         cnt_ff   <= '0;
         sign_ff  <= 1'b0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         cnt_ff   <= cnt_in;
         sign_ff  <= sign_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      for (int i = 0; i < MAG_W; i++) begin
         stack_ff[i] <= stack_in[i];
      end
   end

   // radix register never leaves its legal range
   a_radix_legal: assert property (@(posedge clock) disable iff (reset)
      (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX))
      else $error("radix out of range");

   // emitting always has at least one digit behind it
   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cnt_ff != '0))
      else $error("emit with empty digit stack");

   // digit on top of the stack is a valid digit of the radix
   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !sign_ff) |-> (stack_ff[0] < radix_ff))
      else $error("digit not below radix");

   // final character returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("not idle after last character");

   // a sign is only owed for decimal output
   a_sign_decimal: assert property (@(posedge clock) disable iff (reset)
      sign_ff |-> (radix_ff == RADIX_DEC))
      else $error("sign pending outside radix ten");

endmodule
`default_nettype wire
